>>> hw/rtl/nct_pkg.sv
// shared types and constants for the nearest centroid tracker
package nct_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int COORD_BITS_DEF  = 24;
   localparam int HIT_W           = 16;
   localparam int TIME_W          = 32;
   localparam int ID_W            = 16;
   localparam int ACC_W           = 34;

   localparam logic [HIT_W-1:0] HIT_MAX = '1;

   localparam logic [1:0] CMD_MEAS  = 2'd0;
   localparam logic [1:0] CMD_POSE  = 2'd1;
   localparam logic [1:0] CMD_PRUNE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_MATCHED = 2'd1;
   localparam logic [1:0] STAT_CREATED = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam logic [1:0] CSR_MATCH_RADIUS   = 2'd0;
   localparam logic [1:0] CSR_REACHED_RADIUS = 2'd1;
   localparam logic [1:0] CSR_STALE_TIMEOUT  = 2'd2;
   localparam logic [1:0] CSR_CONFIRM_THRESH = 2'd3;

   localparam logic [15:0] MATCH_RADIUS_RST   = 16'd192;
   localparam logic [15:0] REACHED_RADIUS_RST = 16'd256;
   localparam logic [31:0] STALE_TIMEOUT_RST  = 32'd60000;
   localparam logic [15:0] CONFIRM_THRESH_RST = 16'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_ADDR,
      ST_SCAN_SQ,
      ST_SCAN_EVAL,
      ST_SCAN_END,
      ST_MEAS_RD,
      ST_MEAS_LOAD,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_VIS_CHK,
      ST_VIS_SQ,
      ST_VIS_EVAL,
      ST_WRITE,
      ST_READ_ADDR,
      ST_READ_DATA
   } state_type;

endpackage

>>> hw/rtl/nearest_centroid_tracker.sv
// nearest centroid tracker: slot table in one synchronous memory, sequencer and divider
//
// One request at a time; busy is high from acceptance until the result strobe, which
// is one cycle long and cannot be held off. Every command but a read scans all slots,
// with no memory read for an empty slot, and the scan ends in ST_SCAN_END. A measurement
// reads each valid slot, forms three squared distances through the one shared squaring
// unit and compares; a match then rereads its slot (ST_MEAS_RD, ST_MEAS_LOAD) and runs
// three restoring divisions, one per axis, before the visited check and write back.
// A robot pose forms two squared distances per valid slot, a prune compares ages
// only, and a read fetches its slot (ST_READ_ADDR, ST_READ_DATA), or answers without
// a memory read for an empty or absent slot.
// No clearing pass after reset.
module nearest_centroid_tracker #(
   parameter int TABLE_DEPTH = nct_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = nct_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic [31:0]                  req_timestamp,
   input  logic [3:0]                   req_read_slot,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [15:0]                  rsp_entry_id,
   output logic [3:0]                   rsp_entry_slot,
   output logic                         rsp_entry_valid,
   output logic signed [COORD_BITS-1:0] rsp_centroid_x,
   output logic signed [COORD_BITS-1:0] rsp_centroid_y,
   output logic signed [COORD_BITS-1:0] rsp_centroid_z,
   output logic [15:0]                  rsp_hit_count,
   output logic                         rsp_visited,
   output logic                         rsp_confirmed,
   output logic [4:0]                   rsp_changed_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_wdata
);
   import nct_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int DW     = C + 1;
   localparam int CNT_W  = $clog2(DW + 1);
   localparam int MW     = (C + 1 > 17) ? C + 1 : 17;
   localparam int O_HITS = 3 * C;
   localparam int O_LAST = O_HITS + HIT_W;
   localparam int O_VIS  = O_LAST + TIME_W;
   localparam int O_ID   = O_VIS + 1;
   localparam int REC_W  = O_ID + ID_W;

   state_type state_ff, state_in;

   logic [15:0] match_radius_ff, reached_radius_ff, confirm_thresh_ff;
   logic [31:0] stale_timeout_ff;

   logic [REC_W-1:0] mem [TABLE_DEPTH];
   logic [REC_W-1:0] rd_ff;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [REC_W-1:0] wr_data;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [1:0]             cmd_ff;
   logic signed [C-1:0]    px_ff, py_ff, pz_ff;
   logic [31:0]            ts_ff;
   logic [3:0]             rs_ff;
   logic signed [C-1:0]    robot_x_ff, robot_y_ff;
   logic                   robot_known_ff;
   logic [ID_W-1:0]        id_counter_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [1:0]       ax_ff;
   logic [ACC_W-1:0] acc_ff;
   logic             best_found_ff, free_found_ff;
   logic [IDX_W-1:0] best_idx_ff, free_idx_ff;
   logic [ACC_W-1:0] best_d_ff;
   logic [ID_W-1:0]  best_id_ff;
   logic [4:0]       changed_ff;

   logic signed [C-1:0] wc_ff [3];
   logic [HIT_W-1:0]    whits_ff;
   logic                wvis_ff, wcreate_ff;
   logic [ID_W-1:0]     wid_ff;
   logic [IDX_W-1:0]    wslot_ff;

   logic [DW-1:0]    dq_ff;
   logic [HIT_W-1:0] drem_ff;
   logic             dneg_ff;
   logic [CNT_W-1:0] dcnt_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [15:0]           rsp_id_ff, rsp_hits_ff;
   logic [3:0]            rsp_slot_ff;
   logic                  rsp_ev_ff, rsp_vis_ff, rsp_conf_ff;
   logic signed [C-1:0]   rsp_cx_ff, rsp_cy_ff, rsp_cz_ff;
   logic [4:0]            rsp_changed_ff;

   // fields of the slot just read
   logic signed [C-1:0] rd_c [3];
   logic [HIT_W-1:0]    rd_hits;
   logic [TIME_W-1:0]   rd_last;
   logic                rd_vis;
   logic [ID_W-1:0]     rd_id;

   assign rd_c[0] = rd_ff[C-1:0];
   assign rd_c[1] = rd_ff[2*C-1:C];
   assign rd_c[2] = rd_ff[3*C-1:2*C];
   assign rd_hits = rd_ff[O_LAST-1:O_HITS];
   assign rd_last = rd_ff[O_VIS-1:O_LAST];
   assign rd_vis  = rd_ff[O_VIS];
   assign rd_id   = rd_ff[O_ID+ID_W-1:O_ID];

   logic last_idx, idx_valid, accept, vis_phase;
   logic [6:0] rs_wide;
   logic rs_ok;
   logic [IDX_W-1:0] rs_idx;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_idx  = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign idx_valid = valid_ff[idx_ff];
   assign vis_phase = (state_ff == ST_VIS_SQ);
   assign rs_wide   = 7'(rs_ff);
   assign rs_idx    = rs_wide[IDX_W-1:0];
   assign rs_ok     = (rs_wide < 7'(TABLE_DEPTH)) && valid_ff[rs_idx];

   // shared squared distance unit
   logic signed [C-1:0] sq_a, sq_b;
   logic signed [C:0]   sq_diff;
   logic [MW-1:0]       sq_mag;
   logic [16:0]         sq_clamp;
   logic [ACC_W-1:0]    sq_val;

   always_comb begin
      sq_a = vis_phase ? wc_ff[ax_ff] : rd_c[ax_ff];
      if (vis_phase || cmd_ff == CMD_POSE) begin
         sq_b = (ax_ff == 2'd0) ? robot_x_ff : robot_y_ff;
      end else begin
         case (ax_ff)
            2'd0:    sq_b = px_ff;
            2'd1:    sq_b = py_ff;
            default: sq_b = pz_ff;
         endcase
      end
      sq_diff  = (C+1)'(sq_a) - (C+1)'(sq_b);
      sq_mag   = MW'(sq_diff[C] ? -sq_diff : sq_diff);
      sq_clamp = (sq_mag > MW'(65536)) ? 17'd65536 : sq_mag[16:0];
      sq_val   = ACC_W'(sq_clamp) * ACC_W'(sq_clamp);
   end

   logic [31:0]      r2_match, r2_reach;
   logic             meas_hit, meas_better, pose_hit, prune_hit, near_hit;
   logic [TIME_W-1:0] age;

   assign r2_match    = 32'(match_radius_ff) * 32'(match_radius_ff);
   assign r2_reach    = 32'(reached_radius_ff) * 32'(reached_radius_ff);
   assign meas_hit    = acc_ff < ACC_W'(r2_match);
   assign meas_better = !best_found_ff || (acc_ff < best_d_ff) ||
                        ((acc_ff == best_d_ff) && (rd_id < best_id_ff));
   assign near_hit    = acc_ff <= ACC_W'(r2_reach);
   assign pose_hit    = !rd_vis && near_hit;
   assign age         = ts_ff - rd_last;
   assign prune_hit   = (ts_ff >= rd_last) && (age > stale_timeout_ff);

   // divider step
   logic [16:0]      div_shift;
   logic             div_ge;
   logic signed [C:0] div_diff;
   logic signed [C+1:0] div_q, div_sum;

   always_comb begin
      div_shift = {drem_ff, dq_ff[DW-1]};
      div_ge    = div_shift >= {1'b0, whits_ff};
      case (ax_ff)
         2'd0:    div_diff = (C+1)'(px_ff) - (C+1)'(wc_ff[0]);
         2'd1:    div_diff = (C+1)'(py_ff) - (C+1)'(wc_ff[1]);
         default: div_diff = (C+1)'(pz_ff) - (C+1)'(wc_ff[2]);
      endcase
      div_q   = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      div_sum = (C+2)'(wc_ff[ax_ff]) + div_q;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_command == CMD_READ) ? ST_READ_ADDR : ST_SCAN_ADDR;
            end
         end
         ST_SCAN_ADDR: begin
            if (!idx_valid) begin
               state_in = last_idx ? ST_SCAN_END : ST_SCAN_ADDR;
            end else if (cmd_ff == CMD_PRUNE) begin
               state_in = ST_SCAN_EVAL;
            end else begin
               state_in = ST_SCAN_SQ;
            end
         end
         ST_SCAN_SQ: begin
            if (ax_ff == ((cmd_ff == CMD_MEAS) ? 2'd2 : 2'd1)) begin
               state_in = ST_SCAN_EVAL;
            end
         end
         ST_SCAN_EVAL: state_in = last_idx ? ST_SCAN_END : ST_SCAN_ADDR;
         ST_SCAN_END: begin
            if (cmd_ff != CMD_MEAS) begin
               state_in = ST_IDLE;
            end else if (best_found_ff) begin
               state_in = ST_MEAS_RD;
            end else if (free_found_ff) begin
               state_in = ST_VIS_CHK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MEAS_RD:   state_in = ST_MEAS_LOAD;
         ST_MEAS_LOAD: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (dcnt_ff == CNT_W'(1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: state_in = (ax_ff == 2'd2) ? ST_VIS_CHK : ST_DIV_LOAD;
         ST_VIS_CHK:  state_in = (robot_known_ff && !wvis_ff) ? ST_VIS_SQ : ST_WRITE;
         ST_VIS_SQ: begin
            if (ax_ff == 2'd1) begin
               state_in = ST_VIS_EVAL;
            end
         end
         ST_VIS_EVAL:  state_in = ST_WRITE;
         ST_WRITE:     state_in = ST_IDLE;
         ST_READ_ADDR: state_in = rs_ok ? ST_READ_DATA : ST_IDLE;
         ST_READ_DATA: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      case (state_ff)
         ST_SCAN_ADDR: rd_en = idx_valid;
         ST_MEAS_RD: begin
            rd_en   = 1'b1;
            rd_addr = best_idx_ff;
         end
         ST_READ_ADDR: begin
            rd_en   = rs_ok;
            rd_addr = rs_idx;
         end
         ST_SCAN_EVAL: begin
            wr_en          = (cmd_ff == CMD_POSE) && pose_hit;
            wr_data[O_VIS] = 1'b1;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = wslot_ff;
            wr_data = {wid_ff, wvis_ff, ts_ff, whits_ff, wc_ff[2], wc_ff[1], wc_ff[0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_radius_ff   <= MATCH_RADIUS_RST;
         reached_radius_ff <= REACHED_RADIUS_RST;
         stale_timeout_ff  <= STALE_TIMEOUT_RST;
         confirm_thresh_ff <= CONFIRM_THRESH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MATCH_RADIUS:   match_radius_ff   <= csr_wdata[15:0];
            CSR_REACHED_RADIUS: reached_radius_ff <= csr_wdata[15:0];
            CSR_STALE_TIMEOUT:  stale_timeout_ff  <= csr_wdata;
            CSR_CONFIRM_THRESH: confirm_thresh_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         id_counter_ff  <= '0;
         robot_x_ff     <= '0;
         robot_y_ff     <= '0;
         robot_known_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (accept && req_command == CMD_POSE) begin
            robot_x_ff     <= req_pos_x;
            robot_y_ff     <= req_pos_y;
            robot_known_ff <= 1'b1;
         end
         if (state_ff == ST_SCAN_EVAL && cmd_ff == CMD_PRUNE && prune_hit) begin
            valid_ff[idx_ff] <= 1'b0;
         end
         if (state_ff == ST_WRITE) begin
            valid_ff[wslot_ff] <= 1'b1;
            if (wcreate_ff) begin
               id_counter_ff <= id_counter_ff + 1'b1;
            end
         end
         if ((state_ff == ST_SCAN_END && state_in == ST_IDLE) || state_ff == ST_WRITE ||
             state_ff == ST_READ_DATA || (state_ff == ST_READ_ADDR && !rs_ok)) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_ff        <= req_command;
               px_ff         <= req_pos_x;
               py_ff         <= req_pos_y;
               pz_ff         <= req_pos_z;
               ts_ff         <= req_timestamp;
               rs_ff         <= req_read_slot;
               idx_ff        <= '0;
               best_found_ff <= 1'b0;
               free_found_ff <= 1'b0;
               changed_ff    <= '0;
            end
         end
         ST_SCAN_ADDR: begin
            ax_ff  <= 2'd0;
            acc_ff <= '0;
            if (!idx_valid) begin
               if (!free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= idx_ff;
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_SCAN_SQ: begin
            acc_ff <= acc_ff + sq_val;
            ax_ff  <= ax_ff + 2'd1;
         end
         ST_SCAN_EVAL: begin
            idx_ff <= idx_ff + 1'b1;
            if (cmd_ff == CMD_MEAS && meas_hit && meas_better) begin
               best_found_ff <= 1'b1;
               best_idx_ff   <= idx_ff;
               best_d_ff     <= acc_ff;
               best_id_ff    <= rd_id;
            end
            if ((cmd_ff == CMD_POSE && pose_hit) || (cmd_ff == CMD_PRUNE && prune_hit)) begin
               if (changed_ff != 5'd31) begin
                  changed_ff <= changed_ff + 5'd1;
               end
            end
         end
         ST_SCAN_END: begin
            wc_ff[0]   <= px_ff;
            wc_ff[1]   <= py_ff;
            wc_ff[2]   <= pz_ff;
            whits_ff   <= HIT_W'(1);
            wvis_ff    <= 1'b0;
            wid_ff     <= id_counter_ff;
            wslot_ff   <= free_idx_ff;
            wcreate_ff <= 1'b1;
         end
         ST_MEAS_LOAD: begin
            wc_ff[0]   <= rd_c[0];
            wc_ff[1]   <= rd_c[1];
            wc_ff[2]   <= rd_c[2];
            whits_ff   <= (rd_hits == HIT_MAX) ? HIT_MAX : rd_hits + 1'b1;
            wvis_ff    <= rd_vis;
            wid_ff     <= rd_id;
            wslot_ff   <= best_idx_ff;
            wcreate_ff <= 1'b0;
            ax_ff      <= 2'd0;
         end
         ST_DIV_LOAD: begin
            dneg_ff <= div_diff[C];
            dq_ff   <= DW'(div_diff[C] ? -div_diff : div_diff);
            drem_ff <= '0;
            dcnt_ff <= CNT_W'(DW);
         end
         ST_DIV_RUN: begin
            drem_ff <= div_ge ? HIT_W'(div_shift - {1'b0, whits_ff}) : div_shift[HIT_W-1:0];
            dq_ff   <= {dq_ff[DW-2:0], div_ge};
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         ST_DIV_DONE: begin
            wc_ff[ax_ff] <= div_sum[C-1:0];
            ax_ff        <= ax_ff + 2'd1;
         end
         ST_VIS_CHK: begin
            ax_ff  <= 2'd0;
            acc_ff <= '0;
         end
         ST_VIS_SQ: begin
            acc_ff <= acc_ff + sq_val;
            ax_ff  <= ax_ff + 2'd1;
         end
         ST_VIS_EVAL: begin
            if (near_hit) begin
               wvis_ff    <= 1'b1;
               changed_ff <= 5'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // result registers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN_END && state_in == ST_IDLE) ||
          (state_ff == ST_READ_ADDR && !rs_ok)) begin
         rsp_status_ff  <= (state_ff == ST_SCAN_END && cmd_ff == CMD_MEAS) ? STAT_FULL
                                                                             : STAT_DONE;
         rsp_id_ff      <= '0;
         rsp_slot_ff    <= (state_ff == ST_READ_ADDR) ? rs_ff : 4'd0;
         rsp_ev_ff      <= 1'b0;
         rsp_cx_ff      <= '0;
         rsp_cy_ff      <= '0;
         rsp_cz_ff      <= '0;
         rsp_hits_ff    <= '0;
         rsp_vis_ff     <= 1'b0;
         rsp_conf_ff    <= 1'b0;
         rsp_changed_ff <= (state_ff == ST_SCAN_END && cmd_ff != CMD_MEAS) ? changed_ff
                                                                            : 5'd0;
      end else if (state_ff == ST_WRITE) begin
         rsp_status_ff  <= wcreate_ff ? STAT_CREATED : STAT_MATCHED;
         rsp_id_ff      <= wid_ff;
         rsp_slot_ff    <= 4'(wslot_ff);
         rsp_ev_ff      <= 1'b1;
         rsp_cx_ff      <= wc_ff[0];
         rsp_cy_ff      <= wc_ff[1];
         rsp_cz_ff      <= wc_ff[2];
         rsp_hits_ff    <= whits_ff;
         rsp_vis_ff     <= wvis_ff;
         rsp_conf_ff    <= whits_ff >= confirm_thresh_ff;
         rsp_changed_ff <= changed_ff;
      end else if (state_ff == ST_READ_DATA) begin
         rsp_status_ff  <= STAT_DONE;
         rsp_id_ff      <= rd_id;
         rsp_slot_ff    <= rs_ff;
         rsp_ev_ff      <= 1'b1;
         rsp_cx_ff      <= rd_c[0];
         rsp_cy_ff      <= rd_c[1];
         rsp_cz_ff      <= rd_c[2];
         rsp_hits_ff    <= rd_hits;
         rsp_vis_ff     <= rd_vis;
         rsp_conf_ff    <= rd_hits >= confirm_thresh_ff;
         rsp_changed_ff <= 5'd0;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_id      = rsp_id_ff;
   assign rsp_entry_slot    = rsp_slot_ff;
   assign rsp_entry_valid   = rsp_ev_ff;
   assign rsp_centroid_x    = rsp_cx_ff;
   assign rsp_centroid_y    = rsp_cy_ff;
   assign rsp_centroid_z    = rsp_cz_ff;
   assign rsp_hit_count     = rsp_hits_ff;
   assign rsp_visited       = rsp_vis_ff;
   assign rsp_confirmed     = rsp_conf_ff;
   assign rsp_changed_count = rsp_changed_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid)) else $error("request not taken up");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (whits_ff != '0)) else $error("zero divisor");

endmodule
